### rtl/iur_pkg.sv
// shared types, constants and checksum helpers for the ipv4/udp frame rewriter
// no dependencies; imported by every module of the block
`default_nettype none

package iur_pkg;

    // stream payload widths
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 24;
    localparam int OFF_W      = 11;

    localparam int DEF_MAX_FRAME_BYTES = 2048;

    // result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_PATCH = 1'b1;

    // protocol constants
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;
    localparam logic [3:0]  IHL_MIN       = 4'd5;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

    // frame offsets
    localparam logic [OFF_W-1:0] OFF_IP_CSUM_HI = 11'd24;
    localparam logic [OFF_W-1:0] OFF_IP_CSUM_LO = 11'd25;

    // patch sequencer codes
    localparam logic [2:0] PATCH_IDLE   = 3'd0;
    localparam logic [2:0] PATCH_IP_HI  = 3'd1;
    localparam logic [2:0] PATCH_IP_LO  = 3'd2;
    localparam logic [2:0] PATCH_UDP_HI = 3'd3;
    localparam logic [2:0] PATCH_UDP_LO = 3'd4;

    typedef struct packed {
        logic             kind;
        logic [OFF_W-1:0] offset;
        logic [7:0]       value;
        logic             drop;
        logic             last;
    } iur_res_t;

    typedef struct packed {
        logic [15:0] hs;      // finished ip header checksum
        logic [15:0] usum;    // running udp sum over the udp bytes
        logic [15:0] pseudo;  // pseudo-header sum
        logic [6:0]  u0;      // offset of the udp header
    } iur_patch_t;

    typedef struct packed {
        logic free;  // result register can take a new transaction
        logic busy;  // patch bytes still to be emitted
    } iur_status_t;

    // end-around-carry add of two 16-bit words
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            oc_add = s[15:0] + {15'd0, s[16]};
        end
    endfunction

    // byte i of a mac address, most significant first
    function automatic logic [7:0] mac_byte(input logic [47:0] m, input logic [2:0] i);
        begin
            case (i)
                3'd0:    mac_byte = m[47:40];
                3'd1:    mac_byte = m[39:32];
                3'd2:    mac_byte = m[31:24];
                3'd3:    mac_byte = m[23:16];
                3'd4:    mac_byte = m[15:8];
                3'd5:    mac_byte = m[7:0];
                default: mac_byte = 8'd0;
            endcase
        end
    endfunction

    // byte i of an ipv4 address, most significant first
    function automatic logic [7:0] ip_byte(input logic [31:0] a, input logic [1:0] i);
        begin
            case (i)
                2'd0:    ip_byte = a[31:24];
                2'd1:    ip_byte = a[23:16];
                2'd2:    ip_byte = a[15:8];
                default: ip_byte = a[7:0];
            endcase
        end
    endfunction

endpackage

`default_nettype wire

### rtl/iur_byte_proc.sv
// per-byte rewrite and checksum accumulation with the per-frame state
// depends on iur_pkg
`default_nettype none

module iur_byte_proc #(
    parameter int MAX_FRAME_BYTES = iur_pkg::DEF_MAX_FRAME_BYTES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    input  wire logic [7:0]          frame_byte,
    input  wire logic                last_byte,
    input  wire logic [47:0]         new_src_mac,
    input  wire logic [47:0]         new_dst_mac,
    input  wire logic [31:0]         new_src_ip,
    input  wire logic [31:0]         new_dst_ip,
    output iur_pkg::iur_res_t        res,
    output logic                     patch_req,
    output iur_pkg::iur_patch_t      patch
);
    import iur_pkg::*;

    // position is at least as wide as the offset field it feeds
    localparam int PB = $clog2(MAX_FRAME_BYTES + 1);
    localparam int PW = (PB > OFF_W) ? PB : OFF_W;
    localparam int CW = ((PW > 16) ? PW : 16) + 1;

    logic [PW-1:0] pos_reg;
    logic [15:0]   ftype_reg, ftype_next;
    logic [3:0]    ihl_reg, ihl_next;
    logic [7:0]    proto_reg, proto_next;
    logic [15:0]   ulen_reg, ulen_next;
    logic [15:0]   hsum_reg, hsum_next;
    logic [15:0]   usum_reg, usum_next;
    logic [15:0]   pseudo_reg, pseudo_next;
    logic [7:0]    pend_reg, pend_next;
    logic [47:0]   smac_reg, dmac_reg;
    logic [31:0]   sip_reg, dip_reg;

    logic [47:0]   smac_cur, dmac_cur;
    logic [31:0]   sip_cur, dip_cur;
    logic [5:0]    lp;
    logic          p_lo;
    logic          ip;
    logic [7:0]    v;
    logic [6:0]    u0;
    logic [PW-1:0] rel;
    logic          udp_ok;

    assign p_lo = pos_reg < PW'(64);
    assign lp   = pos_reg[5:0];

    always_comb
    begin
        smac_cur    = (pos_reg == '0) ? new_src_mac : smac_reg;
        dmac_cur    = (pos_reg == '0) ? new_dst_mac : dmac_reg;
        sip_cur     = (pos_reg == '0) ? new_src_ip  : sip_reg;
        dip_cur     = (pos_reg == '0) ? new_dst_ip  : dip_reg;
        ftype_next  = ftype_reg;
        ihl_next    = ihl_reg;
        proto_next  = proto_reg;
        ulen_next   = ulen_reg;
        hsum_next   = hsum_reg;
        usum_next   = usum_reg;
        pseudo_next = pseudo_reg;
        pend_next   = pend_reg;
        v           = frame_byte;

        // mac rewrite and ethertype capture
        if (p_lo && lp < 6'd6)
            v = mac_byte(dmac_cur, lp[2:0]);
        else if (p_lo && lp < 6'd12)
            v = mac_byte(smac_cur, 3'(lp - 6'd6));
        else if (p_lo && lp == 6'd12)
            ftype_next = {frame_byte, 8'd0};
        else if (p_lo && lp == 6'd13)
            ftype_next = {ftype_reg[15:8], frame_byte};

        // pseudo-header words folded in early in the frame
        if (p_lo && lp == 6'd1) pseudo_next = oc_add(pseudo_reg, sip_reg[31:16]);
        if (p_lo && lp == 6'd2) pseudo_next = oc_add(pseudo_reg, sip_reg[15:0]);
        if (p_lo && lp == 6'd3) pseudo_next = oc_add(pseudo_reg, dip_reg[31:16]);
        if (p_lo && lp == 6'd4) pseudo_next = oc_add(pseudo_reg, dip_reg[15:0]);
        if (p_lo && lp == 6'd5) pseudo_next = oc_add(pseudo_reg, {8'd0, IP_PROTO_UDP});

        ip = (ftype_next == ETH_TYPE_IPV4);
        if (ip && p_lo && lp >= 6'd14)
        begin
            if (lp == 6'd14) ihl_next = frame_byte[3:0];
            if (lp == 6'd23) proto_next = frame_byte;
            if (lp == 6'd24 || lp == 6'd25) v = 8'd0;
            if (lp >= 6'd26 && lp < 6'd30) v = ip_byte(sip_cur, 2'(lp - 6'd26));
            if (lp >= 6'd30 && lp < 6'd34) v = ip_byte(dip_cur, 2'(lp - 6'd30));
        end

        u0  = 7'd14 + {1'b0, ihl_next, 2'b00};
        rel = pos_reg - PW'(u0);

        if (ip && pos_reg >= PW'(14) && pos_reg < PW'(u0))
        begin
            // ip header words
            if (!pos_reg[0]) pend_next = v;
            else             hsum_next = oc_add(hsum_reg, {pend_reg, v});
        end
        else if (ip && ihl_next >= IHL_MIN && pos_reg >= PW'(u0))
        begin
            if (rel == PW'(4)) ulen_next = {frame_byte, 8'd0};
            if (rel == PW'(5)) ulen_next = {ulen_reg[15:8], frame_byte};
            if (rel == PW'(6) || rel == PW'(7)) v = 8'd0;
            if (rel == PW'(6)) pseudo_next = oc_add(pseudo_reg, ulen_reg);
            if (rel < PW'(8) || CW'(rel) < CW'(ulen_next))
            begin
                if (!rel[0])
                begin
                    pend_next = v;
                    // odd udp length: last byte padded with zero
                    if (rel >= PW'(8) && CW'(rel) + CW'(1) == CW'(ulen_next))
                        usum_next = oc_add(usum_reg, {v, 8'd0});
                end
                else
                begin
                    usum_next = oc_add(usum_reg, {pend_reg, v});
                end
            end
        end

        udp_ok = ip && ihl_next >= IHL_MIN && proto_next == IP_PROTO_UDP
              && CW'(pos_reg) + CW'(1) >= CW'(u0) + CW'(8)
              && ulen_next >= UDP_HDR_BYTES
              && CW'(pos_reg) + CW'(1) >= CW'(u0) + CW'(ulen_next)
              && CW'(pos_reg) < CW'(MAX_FRAME_BYTES);

        res.kind   = KIND_BYTE;
        res.offset = pos_reg[OFF_W-1:0];
        res.value  = v;
        res.drop   = last_byte && !udp_ok;
        res.last   = last_byte && !udp_ok;

        patch_req    = last_byte && udp_ok;
        patch.hs     = ~hsum_next;
        patch.usum   = usum_next;
        patch.pseudo = pseudo_next;
        patch.u0     = u0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ftype_reg  <= '0;
            ihl_reg    <= '0;
            proto_reg  <= '0;
            ulen_reg   <= '0;
            hsum_reg   <= '0;
            usum_reg   <= '0;
            pseudo_reg <= '0;
            pend_reg   <= '0;
        end
        else if (item_valid)
        begin
            if (last_byte)
            begin
                pos_reg    <= '0;
                ftype_reg  <= '0;
                ihl_reg    <= '0;
                proto_reg  <= '0;
                ulen_reg   <= '0;
                hsum_reg   <= '0;
                usum_reg   <= '0;
                pseudo_reg <= '0;
                pend_reg   <= '0;
            end
            else
            begin
                if (CW'(pos_reg) < CW'(MAX_FRAME_BYTES))
                    pos_reg <= pos_reg + PW'(1);
                ftype_reg  <= ftype_next;
                ihl_reg    <= ihl_next;
                proto_reg  <= proto_next;
                ulen_reg   <= ulen_next;
                hsum_reg   <= hsum_next;
                usum_reg   <= usum_next;
                pseudo_reg <= pseudo_next;
                pend_reg   <= pend_next;
            end
        end
    end

    // addresses held for the frame
    always_ff @(posedge clk)
    begin
        if (item_valid && pos_reg == '0)
        begin
            smac_reg <= new_src_mac;
            dmac_reg <= new_dst_mac;
            sip_reg  <= new_src_ip;
            dip_reg  <= new_dst_ip;
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(pos_reg) <= CW'(MAX_FRAME_BYTES))
        else $error("byte position past frame limit");

    a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && last_byte) |=> (pos_reg == '0))
        else $error("byte position not cleared after final byte");

endmodule

`default_nettype wire

### rtl/iur_out_stage.sv
// result register and checksum patch sequencer
// depends on iur_pkg
`default_nettype none

module iur_out_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load_byte,
    input  wire iur_pkg::iur_res_t     res,
    input  wire logic                  patch_req,
    input  wire iur_pkg::iur_patch_t   patch,
    output iur_pkg::iur_status_t       status,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [iur_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast,
    output logic [0:0]                 m_axis_tuser
);
    import iur_pkg::*;

    logic        out_valid_reg;
    iur_res_t    out_res_reg;
    iur_res_t    patch_res;
    logic [2:0]  pidx_reg, pidx_next;
    iur_patch_t  patch_reg;
    logic [15:0] us_reg;
    logic [15:0] us_sum, us_final;
    logic        free, busy;

    assign free = !out_valid_reg || m_axis_tready;
    assign busy = (pidx_reg != PATCH_IDLE);
    assign status.free = free;
    assign status.busy = busy;

    // udp checksum: fold pseudo-header, complement, zero goes out as all ones
    always_comb
    begin
        us_sum   = oc_add(patch_reg.usum, patch_reg.pseudo);
        us_final = ~us_sum;
        if (us_final == 16'd0)
            us_final = 16'hFFFF;
    end

    always_comb
    begin
        patch_res.kind = KIND_PATCH;
        patch_res.drop = 1'b0;
        patch_res.last = 1'b0;
        pidx_next      = pidx_reg + 3'd1;
        unique case (pidx_reg)
            PATCH_IP_HI:
            begin
                patch_res.offset = OFF_IP_CSUM_HI;
                patch_res.value  = patch_reg.hs[15:8];
            end
            PATCH_IP_LO:
            begin
                patch_res.offset = OFF_IP_CSUM_LO;
                patch_res.value  = patch_reg.hs[7:0];
            end
            PATCH_UDP_HI:
            begin
                patch_res.offset = OFF_W'(patch_reg.u0) + OFF_W'(6);
                patch_res.value  = us_reg[15:8];
            end
            PATCH_UDP_LO:
            begin
                patch_res.offset = OFF_W'(patch_reg.u0) + OFF_W'(7);
                patch_res.value  = us_reg[7:0];
                patch_res.last   = 1'b1;
                pidx_next        = PATCH_IDLE;
            end
            default:
            begin
                patch_res.offset = '0;
                patch_res.value  = '0;
                pidx_next        = PATCH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pidx_reg      <= PATCH_IDLE;
        end
        else if (free)
        begin
            if (busy)
            begin
                out_valid_reg <= 1'b1;
                pidx_reg      <= pidx_next;
            end
            else if (load_byte)
            begin
                out_valid_reg <= 1'b1;
                if (patch_req)
                    pidx_reg <= PATCH_IP_HI;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free)
        begin
            if (busy)
            begin
                out_res_reg <= patch_res;
                if (pidx_reg == PATCH_IP_HI)
                    us_reg <= us_final;
            end
            else if (load_byte)
            begin
                out_res_reg <= res;
                if (patch_req)
                    patch_reg <= patch;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_res_reg.drop, out_res_reg.value, out_res_reg.offset};
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tuser  = out_res_reg.kind;

    a_pidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        pidx_reg <= PATCH_UDP_LO)
        else $error("patch index out of range");

    a_patch_start: assert property (@(posedge clk) disable iff (!rst_n)
        (free && !busy && load_byte && patch_req) |=> (pidx_reg == PATCH_IP_HI))
        else $error("patch sequence did not start after good final byte");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_byte && busy))
        else $error("byte loaded while patches pending");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.last && out_res_reg.kind == KIND_BYTE)
            |-> out_res_reg.drop)
        else $error("byte result closes a frame that is not dropped");

endmodule

`default_nettype wire

### rtl/ipv4_udp_frame_rewriter.sv
// top level of the ipv4/udp frame rewriter: input register, byte processor, result stage
// depends on iur_pkg, iur_byte_proc and iur_out_stage
//
// usage
//   s_axis carries one frame byte per transaction, tlast on the final byte.
//   the four new addresses ride along in tdata and are sampled on the first
//   byte of each frame only.
//   m_axis carries one result per transaction: tuser says rewritten byte or
//   checksum patch byte, tdata holds offset, value and drop, tlast closes
//   the frame's results.
// each byte passes through the input register, then the result register,
//   before it shows on m_axis.
// throughput: one byte per cycle while m_axis does not stall. the final byte
//   of a good ipv4/udp frame yields five results, so the input is held off while
//   the patch sequencer emits the ip and udp checksum bytes.
// a dropped frame ends with its last byte result carrying drop and tlast.
// reset clears the byte position and all per-frame sums; both valids drop.
// when m_axis stalls, the result register holds and backpressure reaches
//   s_axis_tready in the same cycle once the input register is also full.
`default_nettype none

module ipv4_udp_frame_rewriter #(
    parameter int MAX_FRAME_BYTES = iur_pkg::DEF_MAX_FRAME_BYTES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input frame bytes
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // fields from bit 0: frame_byte[7:0], new_src_mac[55:8], new_dst_mac[103:56],
    // new_src_ip[135:104], new_dst_ip[167:136]
    input  wire logic [iur_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                          s_axis_tlast,   // last_byte
    // output results
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // fields from bit 0: offset[10:0], value[18:11], drop[19], zero pad[23:20]
    output logic [iur_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast,   // last
    output logic [0:0]                         m_axis_tuser    // kind
);
    import iur_pkg::*;

    // input register
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 in_last_reg;

    logic        advance;
    iur_status_t status;
    iur_res_t    res;
    logic        patch_req;
    iur_patch_t  patch;

    // the held byte moves on only when the result register is free and no
    // patch bytes of the previous frame are waiting
    assign advance       = in_valid_reg && status.free && !status.busy;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    iur_byte_proc #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_byte_proc (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (advance),
        .frame_byte  (in_data_reg[7:0]),
        .last_byte   (in_last_reg),
        .new_src_mac (in_data_reg[55:8]),
        .new_dst_mac (in_data_reg[103:56]),
        .new_src_ip  (in_data_reg[135:104]),
        .new_dst_ip  (in_data_reg[167:136]),
        .res         (res),
        .patch_req   (patch_req),
        .patch       (patch)
    );

    iur_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_byte     (advance),
        .res           (res),
        .patch_req     (patch_req),
        .patch         (patch),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_advance_free: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (status.free && !status.busy))
        else $error("byte advanced into a blocked result stage");

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for ipv4_udp_frame_rewriter: a table of directed frames, then random frames
// results are checked against an in-bench model of the address rewrite and both checksums
// depends on iur_pkg and ipv4_udp_frame_rewriter

module testbench;
    import iur_pkg::*;

    localparam int MAX_BYTES   = 2048;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_FRAMES = 2;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP      = 8'h11;

    // how a frame is expected to end: typed in by the table or left to the model
    localparam logic [1:0] FATE_KEEP = 2'd0;
    localparam logic [1:0] FATE_DROP = 2'd1;
    localparam logic [1:0] FATE_ANY  = 2'd2;

    // one directed frame: header fields the block parses, bytes on the wire, expected end
    typedef struct packed {
        logic [15:0] et;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] ulen;
        logic [11:0] total;
        logic        zero_csum;
        logic [1:0]  fate;
    } frame_row_t;

    localparam int N_PLAN = 6;
    localparam frame_row_t PLAN [N_PLAN] = '{
        // minimal good frame straight after reset, all-ones addresses
        '{ETHERTYPE_IPV4, 4'd5,  PROTO_UDP, 16'd8,     12'd42,   1'b0, FATE_KEEP},
        // odd udp length behind a longer ip header, summed with a zero pad; all-zero addresses
        '{ETHERTYPE_IPV4, 4'd6,  PROTO_UDP, 16'd9,     12'd47,   1'b0, FATE_KEEP},
        // payload tuned so the udp checksum comes out zero and goes out as all ones
        '{ETHERTYPE_IPV4, 4'd5,  PROTO_UDP, 16'd10,    12'd44,   1'b1, FATE_KEEP},
        // not ipv4: ends right after the ethertype
        '{ETHERTYPE_IPV6, 4'd5,  PROTO_UDP, 16'd8,     12'd14,   1'b0, FATE_DROP},
        // truncated inside the ip header
        '{ETHERTYPE_IPV4, 4'd5,  PROTO_UDP, 16'd8,     12'd20,   1'b0, FATE_DROP},
        // single-byte frame
        '{ETHERTYPE_IPV4, 4'd5,  PROTO_UDP, 16'd8,     12'd1,    1'b0, FATE_DROP}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;

    // model state, cleared on the first byte of each frame
    logic [11:0] pos_q;
    logic [15:0] etype_q;
    logic [3:0]  ihl_q;
    logic [7:0]  proto_q;
    logic [15:0] ulen_q;
    logic [15:0] hsum_q;
    logic [15:0] usum_q;
    logic [7:0]  hi_q;
    logic [47:0] src_mac_q;
    logic [47:0] dst_mac_q;
    logic [31:0] src_ip_q;
    logic [31:0] dst_ip_q;

    iur_res_t   rewrite_q[$];   // rewritten and patch bytes still to come out
    logic [1:0] fate_q[$];      // one entry per frame sent
    logic [7:0] frame_buf[$];   // wire bytes of the frame being built
    iur_res_t   due;
    logic [1:0] fate;
    logic       calm;           // no idling on either side while set
    int         errors;
    int         cycles = 0;

    ipv4_udp_frame_rewriter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // end-around-carry 16-bit add
    function automatic logic [15:0] ones_add(input int unsigned a, input int unsigned b);
        int unsigned s;
        s = (a & 32'hFFFF) + (b & 32'hFFFF);
        return 16'((s & 32'hFFFF) + (s >> 16));
    endfunction

    function automatic void push_result(input logic kind, input int unsigned off,
                                        input logic [7:0] val, input logic drop,
                                        input logic last);
        iur_res_t r;
        r.kind   = kind;
        r.offset = 11'(off);
        r.value  = val;
        r.drop   = drop;
        r.last   = last;
        rewrite_q.push_back(r);
    endfunction

    // model of one accepted frame byte: queues the results it causes
    function automatic void rewrite_byte(input logic [IN_DATA_W-1:0] d, input logic fin);
        int unsigned p;
        int unsigned u0;
        int unsigned rel;
        logic [7:0]  b;
        logic [7:0]  v;
        logic        ip;
        logic        keep;
        logic [15:0] hs;
        logic [15:0] us;
        if (pos_q == 0)
        begin
            etype_q   = '0;
            ihl_q     = '0;
            proto_q   = '0;
            ulen_q    = '0;
            hsum_q    = '0;
            usum_q    = '0;
            hi_q      = '0;
            src_mac_q = d[55:8];
            dst_mac_q = d[103:56];
            src_ip_q  = d[135:104];
            dst_ip_q  = d[167:136];
        end
        p = pos_q;
        b = d[7:0];
        v = b;

        // ethernet header: both macs replaced, ethertype picked up
        if (p < 6)
            v = 8'(dst_mac_q >> (8 * (5 - p)));
        else if (p < 12)
            v = 8'(src_mac_q >> (8 * (11 - p)));
        else if (p == 12)
            etype_q = {b, 8'h00};
        else if (p == 13)
            etype_q[7:0] = b;

        // ip header: checksum zeroed, both addresses replaced
        ip = (etype_q == ETHERTYPE_IPV4);
        if (ip && p >= 14)
        begin
            if (p == 14)
                ihl_q = b[3:0];
            if (p == 23)
                proto_q = b;
            if (p == 24 || p == 25)
                v = 8'h00;
            if (p >= 26 && p < 30)
                v = 8'(src_ip_q >> (8 * (29 - p)));
            if (p >= 30 && p < 34)
                v = 8'(dst_ip_q >> (8 * (33 - p)));
        end
        u0 = 14 + 4 * ihl_q;

        // header words go into the ip sum, udp words (checksum zeroed) into the udp sum
        if (ip && p >= 14 && p < u0)
        begin
            if (p[0] == 1'b0)
                hi_q = v;
            else
                hsum_q = ones_add(hsum_q, {hi_q, v});
        end
        else if (ip && ihl_q >= 5 && p >= u0)
        begin
            rel = p - u0;
            if (rel == 4)
                ulen_q = {b, 8'h00};
            if (rel == 5)
                ulen_q[7:0] = b;
            if (rel == 6 || rel == 7)
                v = 8'h00;
            if (rel < 8 || rel < ulen_q)
            begin
                if (rel[0] == 1'b0)
                begin
                    hi_q = v;
                    // odd length: the last byte is summed with a zero pad
                    if (rel >= 8 && rel + 1 == ulen_q)
                        usum_q = ones_add(usum_q, {v, 8'h00});
                end
                else
                    usum_q = ones_add(usum_q, {hi_q, v});
            end
        end

        if (!fin)
        begin
            push_result(KIND_BYTE, p, v, 1'b0, 1'b0);
            if (pos_q < MAX_BYTES)
                pos_q = pos_q + 12'd1;
            return;
        end

        keep = ip && ihl_q >= 5 && proto_q == PROTO_UDP && p + 1 >= u0 + 8 && ulen_q >= 8 &&
               p + 1 >= u0 + ulen_q && p < MAX_BYTES;
        pos_q = '0;
        if (!keep)
        begin
            push_result(KIND_BYTE, p, v, 1'b1, 1'b1);
            return;
        end

        // finish both checksums; the udp one adds the pseudo-header
        hs = ~hsum_q;
        us = usum_q;
        us = ones_add(us, src_ip_q[31:16]);
        us = ones_add(us, src_ip_q[15:0]);
        us = ones_add(us, dst_ip_q[31:16]);
        us = ones_add(us, dst_ip_q[15:0]);
        us = ones_add(us, PROTO_UDP);
        us = ones_add(us, ulen_q);
        us = ~us;
        if (us == 16'h0000)
            us = 16'hFFFF;
        push_result(KIND_BYTE,  p,      v,        1'b0, 1'b0);
        push_result(KIND_PATCH, 24,     hs[15:8], 1'b0, 1'b0);
        push_result(KIND_PATCH, 25,     hs[7:0],  1'b0, 1'b0);
        push_result(KIND_PATCH, u0 + 6, us[15:8], 1'b0, 1'b0);
        push_result(KIND_PATCH, u0 + 7, us[7:0],  1'b0, 1'b1);
    endfunction

    // random frame bytes with the parsed header fields put in place
    function automatic void make_frame(input logic [15:0] et, input logic [3:0] ihl,
                                       input logic [7:0] proto, input logic [15:0] ulen,
                                       input int total);
        int         u0;
        logic [7:0] b;
        u0 = 14 + 4 * ihl;
        frame_buf.delete();
        for (int i = 0; i < total; i++)
        begin
            b = 8'($urandom);
            if (i == 12)
                b = et[15:8];
            else if (i == 13)
                b = et[7:0];
            else if (i == 14)
                b[3:0] = ihl;
            else if (i == 23)
                b = proto;
            else if (i == u0 + 4)
                b = ulen[15:8];
            else if (i == u0 + 5)
                b = ulen[7:0];
            frame_buf.push_back(b);
        end
    endfunction

    // set the first payload word so the udp sum folds to all ones; needs an even length of 10+
    function automatic void zero_udp_csum(input int u0, input int ulen,
                                          input logic [31:0] sip, input logic [31:0] dip);
        logic [15:0] s;
        s = ones_add(ones_add(sip[31:16], sip[15:0]), ones_add(dip[31:16], dip[15:0]));
        s = ones_add(s, ones_add(PROTO_UDP, ulen));
        frame_buf[u0 + 6] = 8'h00;
        frame_buf[u0 + 7] = 8'h00;
        frame_buf[u0 + 8] = 8'h00;
        frame_buf[u0 + 9] = 8'h00;
        for (int r = 0; r < ulen; r += 2)
            s = ones_add(s, {frame_buf[u0 + r], frame_buf[u0 + r + 1]});
        frame_buf[u0 + 8] = ~s[15:8];
        frame_buf[u0 + 9] = ~s[7:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // sends frame_buf; the addresses only count on the first byte, the rest carry noise
    task automatic send_frame(input logic [1:0] fate_in, input logic [47:0] smac,
                              input logic [47:0] dmac, input logic [31:0] sip,
                              input logic [31:0] dip);
        logic [IN_DATA_W-1:0] d;
        fate_q.push_back(fate_in);
        foreach (frame_buf[i])
        begin
            if (i == 0)
                d = {dip, sip, dmac, smac, frame_buf[i]};
            else
                d = {32'($urandom), 32'($urandom), 16'($urandom), 32'($urandom),
                     16'($urandom), 32'($urandom), frame_buf[i]};
            // random gap before the transaction, tvalid low meanwhile
            while (!calm && $urandom_range(0, 99) < 28)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= d;
            s_axis_tlast  <= (i == frame_buf.size() - 1);
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
    endtask

    // hold the input off until every queued result has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (rewrite_q.size() != 0);
    endtask

    // result side stalls at random outside the calm stretch
    always @(posedge clk)
    begin
        if (!calm && $urandom_range(0, 99) < 28)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    // both handshakes are sampled here; results are checked before the new byte is modeled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (rewrite_q.size() == 0)
                    report_mismatch($sformatf("unexpected result at offset %0d",
                                              m_axis_tdata[10:0]));
                else
                begin
                    due = rewrite_q.pop_front();
                    if (m_axis_tuser[0] !== due.kind)
                        report_mismatch($sformatf("kind got %0b want %0b",
                                                  m_axis_tuser[0], due.kind));
                    if (m_axis_tdata[10:0] !== due.offset)
                        report_mismatch($sformatf("offset got %0d want %0d",
                                                  m_axis_tdata[10:0], due.offset));
                    if (m_axis_tdata[18:11] !== due.value)
                        report_mismatch($sformatf("value at offset %0d got %02h want %02h",
                                                  due.offset, m_axis_tdata[18:11], due.value));
                    if (m_axis_tdata[19] !== due.drop)
                        report_mismatch($sformatf("drop at offset %0d got %0b want %0b",
                                                  due.offset, m_axis_tdata[19], due.drop));
                    if (m_axis_tlast !== due.last)
                        report_mismatch($sformatf("last at offset %0d got %0b want %0b",
                                                  due.offset, m_axis_tlast, due.last));
                end
                // frames whose outcome the table states are also held to it
                if (m_axis_tlast && fate_q.size() != 0)
                begin
                    fate = fate_q.pop_front();
                    if (fate != FATE_ANY && m_axis_tdata[19] !== fate[0])
                        report_mismatch($sformatf("frame end drop got %0b, table says %0b",
                                                  m_axis_tdata[19], fate[0]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                rewrite_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        frame_row_t  row;
        logic [47:0] smac;
        logic [47:0] dmac;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] et;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] ulen;
        int          u0;
        int          total;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        calm          = 1'b0;
        errors        = 0;
        pos_q         = '0;
        etype_q       = '0;
        ihl_q         = '0;
        proto_q       = '0;
        ulen_q        = '0;
        hsum_q        = '0;
        usum_q        = '0;
        hi_q          = '0;
        src_mac_q     = '0;
        dst_mac_q     = '0;
        src_ip_q      = '0;
        dst_ip_q      = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames: extremes of the header fields and several ways to be dropped
        for (int k = 0; k < N_PLAN; k++)
        begin
            row = PLAN[k];
            // the second frame runs with no idling on either side
            calm = (k == 1);
            if (k == 0)
            begin
                smac = '1;
                dmac = '1;
                sip  = '1;
                dip  = '1;
            end
            else if (k == 1)
            begin
                smac = '0;
                dmac = '0;
                sip  = '0;
                dip  = '0;
            end
            else
            begin
                smac = {16'($urandom), 32'($urandom)};
                dmac = {16'($urandom), 32'($urandom)};
                sip  = $urandom;
                dip  = $urandom;
            end
            make_frame(row.et, row.ihl, row.proto, row.ulen, row.total);
            if (row.zero_csum)
                zero_udp_csum(14 + 4 * row.ihl, row.ulen, sip, dip);
            send_frame(row.fate, smac, dmac, sip, dip);
        end
        calm = 1'b0;
        wait_drained();

        // random frames: mostly well-formed udp with random content, the rest broken
        for (int n = 0; n < RAND_FRAMES; n++)
        begin
            smac = {16'($urandom), 32'($urandom)};
            dmac = {16'($urandom), 32'($urandom)};
            sip  = $urandom;
            dip  = $urandom;
            if ($urandom_range(0, 99) < 75)
            begin
                ihl   = 4'($urandom_range(5, 6));
                ulen  = 16'($urandom_range(8, 12));
                u0    = 14 + 4 * ihl;
                total = u0 + ulen;
                if ($urandom_range(0, 4) == 0)
                    total += $urandom_range(1, 4);
                make_frame(ETHERTYPE_IPV4, ihl, PROTO_UDP, ulen, total);
                if (ulen[0] == 1'b0 && ulen >= 10 && $urandom_range(0, 9) == 0)
                    zero_udp_csum(u0, ulen, sip, dip);
            end
            else
            begin
                et    = $urandom_range(0, 1) ? ETHERTYPE_IPV4 : 16'($urandom);
                ihl   = 4'($urandom);
                proto = $urandom_range(0, 1) ? PROTO_UDP : 8'($urandom);
                ulen  = $urandom_range(0, 1) ? 16'($urandom_range(0, 80)) : 16'($urandom);
                total = $urandom_range(1, 48);
                make_frame(et, ihl, proto, ulen, total);
            end
            send_frame(FATE_ANY, smac, dmac, sip, dip);
        end
        calm = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && rewrite_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### ipv4_udp_frame_rewriter.f
rtl/iur_pkg.sv
rtl/iur_byte_proc.sv
rtl/iur_out_stage.sv
rtl/ipv4_udp_frame_rewriter.sv
tb/testbench.sv
